/* rtl/fbpa_pkg.sv */
`timescale 1ns / 1ps

package fbpa_pkg;

    localparam int BB_W   = 16;
    localparam int PB_W   = 9;
    localparam int FREE_W = 9;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        KIND_ALLOC   = 1'b0,
        KIND_RELEASE = 1'b1
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_BLOCKS = 1'd1;

    localparam logic [BB_W-1:0] BLOCK_BYTES_RST = 16'd16;
    localparam logic [PB_W-1:0] POOL_BLOCKS_RST = 9'd256;

endpackage

/* rtl/fbpa_req_if.sv */
`timescale 1ns / 1ps

interface fbpa_req_if #(
    parameter int OFFSET_BITS = 24
);
    logic                   valid;
    logic                   ready;
    fbpa_pkg::t_kind        kind;
    logic [OFFSET_BITS-1:0] block_offset;

    modport source (output valid, output kind, output block_offset, input ready);
    modport sink   (input valid, input kind, input block_offset, output ready);
endinterface

/* rtl/fbpa_rsp_if.sv */
`timescale 1ns / 1ps

interface fbpa_rsp_if #(
    parameter int OFFSET_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic [OFFSET_BITS-1:0]        granted_offset;
    fbpa_pkg::t_status             status;
    logic [fbpa_pkg::FREE_W-1:0]   free_blocks;

    modport source (output valid, output granted_offset, output status,
                    output free_blocks, input ready);
    modport sink   (input valid, input granted_offset, input status,
                    input free_blocks, output ready);
endinterface

/* rtl/fbpa_stack_mem.sv */
`timescale 1ns / 1ps

module fbpa_stack_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/fixed_block_pool_allocator.sv */
`timescale 1ns / 1ps

// Fixed-size block pool allocator. Free blocks sit on a last-in-first-out stack of byte
// offsets held in a single-port-write, registered-read memory. One request (allocate or
// release) is taken per cycle unless the response side stalls. A response is registered
// in the stage-one registers, with the memory read of the stack top, then in the output
// register. After reset or any write to block_bytes or pool_blocks the stack holds
// offsets i*block_bytes with the last block on top; these reload values come from a
// multiplier on the fly, so a reload needs no pass over the memory. The user must write
// configuration only while no request is outstanding; the block does not enforce it.
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS  = 256,
    parameter int OFFSET_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fbpa_pkg::BB_W-1:0]           i_cfg_data,
    fbpa_req_if.sink                            i_req,
    fbpa_rsp_if.source                          o_rsp
);

    import fbpa_pkg::*;

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int DW = $clog2(MAX_BLOCKS + 1);
    localparam int CW = (DW > PB_W) ? DW : PB_W;
    localparam int PW = AW + BB_W;
    localparam int XW = (PW > OFFSET_BITS) ? PW : OFFSET_BITS;

    function automatic logic [DW-1:0] sat_blocks(input logic [PB_W-1:0] pb);
        logic [CW-1:0] v;
        v = CW'(pb);
        if (v > CW'(MAX_BLOCKS)) begin
            return DW'(MAX_BLOCKS);
        end
        return DW'(v);
    endfunction

    logic [BB_W-1:0] r_block_bytes;
    logic [PB_W-1:0] r_pool_blocks;
    logic [DW-1:0]   r_depth;
    logic [DW-1:0]   r_min;

    logic                   r_s1_valid;
    t_status                r_s1_status;
    logic [DW-1:0]          r_s1_depth;
    logic                   r_s1_pop;
    logic                   r_s1_clean;
    logic [OFFSET_BITS-1:0] r_s1_prod;

    logic                   r_out_valid;
    logic [OFFSET_BITS-1:0] r_out_offset;
    t_status                r_out_status;
    logic [FREE_W-1:0]      r_out_free;

    logic                   accept;
    logic                   advance;
    logic                   cfg_hit;
    logic [DW-1:0]          n_reload;
    logic [DW-1:0]          pop_idx;
    logic [XW-1:0]          prod;
    logic                   is_alloc;
    logic                   do_pop;
    logic                   do_push;
    logic [OFFSET_BITS-1:0] mem_rdata;
    logic [OFFSET_BITS-1:0] s1_offset;

    assign advance      = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready  = !r_s1_valid || advance;
    assign accept       = i_req.valid && i_req.ready;
    assign is_alloc     = (i_req.kind == KIND_ALLOC);
    assign do_pop       = accept && is_alloc && (r_depth != '0);
    assign do_push      = accept && !is_alloc && (r_depth != DW'(MAX_BLOCKS));
    assign pop_idx      = r_depth - DW'(1);
    assign prod         = XW'(pop_idx[AW-1:0]) * XW'(r_block_bytes);
    assign cfg_hit      = i_cfg_we &&
                          (i_cfg_idx == CFG_BLOCK_BYTES || i_cfg_idx == CFG_POOL_BLOCKS);

    always_comb begin
        if (i_cfg_idx == CFG_POOL_BLOCKS) begin
            n_reload = sat_blocks(i_cfg_data[PB_W-1:0]);
        end else begin
            n_reload = sat_blocks(r_pool_blocks);
        end
    end

    fbpa_stack_mem #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH (OFFSET_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (do_push),
        .i_waddr (r_depth[AW-1:0]),
        .i_wdata (i_req.block_offset),
        .i_re    (do_pop),
        .i_raddr (pop_idx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_bytes <= BLOCK_BYTES_RST;
            r_pool_blocks <= POOL_BLOCKS_RST;
            r_depth       <= sat_blocks(POOL_BLOCKS_RST);
            r_min         <= sat_blocks(POOL_BLOCKS_RST);
        end else if (cfg_hit) begin
            if (i_cfg_idx == CFG_BLOCK_BYTES) begin
                r_block_bytes <= i_cfg_data;
            end else begin
                r_pool_blocks <= i_cfg_data[PB_W-1:0];
            end
            r_depth <= n_reload;
            r_min   <= n_reload;
        end else if (do_pop) begin
            r_depth <= pop_idx;
            if (pop_idx < r_min) begin
                r_min <= pop_idx;
            end
        end else if (do_push) begin
            r_depth <= r_depth + DW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pop   <= do_pop;
            r_s1_clean <= pop_idx < r_min;
            r_s1_prod  <= OFFSET_BITS'(prod);
            if (is_alloc && r_depth == '0) begin
                r_s1_status <= ST_EMPTY;
                r_s1_depth  <= r_depth;
            end else if (!is_alloc && r_depth == DW'(MAX_BLOCKS)) begin
                r_s1_status <= ST_FULL;
                r_s1_depth  <= r_depth;
            end else if (is_alloc) begin
                r_s1_status <= ST_OK;
                r_s1_depth  <= pop_idx;
            end else begin
                r_s1_status <= ST_OK;
                r_s1_depth  <= r_depth + DW'(1);
            end
        end
    end

    always_comb begin
        if (!r_s1_pop) begin
            s1_offset = '0;
        end else if (r_s1_clean) begin
            s1_offset = r_s1_prod;
        end else begin
            s1_offset = mem_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_offset <= s1_offset;
            r_out_status <= r_s1_status;
            r_out_free   <= FREE_W'(r_s1_depth);
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.granted_offset = r_out_offset;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.free_blocks    = r_out_free;

endmodule

/* rtl/fbpa_checker.sv */
`timescale 1ns / 1ps

module fbpa_checker #(
    parameter int MAX_BLOCKS  = 256,
    parameter int OFFSET_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rsp_valid,
    input  logic                          i_rsp_ready,
    input  logic [OFFSET_BITS-1:0]        i_rsp_offset,
    input  logic [1:0]                    i_rsp_status,
    input  logic [fbpa_pkg::FREE_W-1:0]   i_rsp_free
);

    import fbpa_pkg::*;

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response withdrawn before its transfer");

    a_empty_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == ST_EMPTY |-> i_rsp_offset == '0 && i_rsp_free == '0)
        else $error("empty response carries an offset or a nonzero free count");

    a_full_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status == ST_FULL
            |-> i_rsp_offset == '0 && i_rsp_free == FREE_W'(MAX_BLOCKS))
        else $error("full response with wrong offset or free count");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid
            |-> i_rsp_status == ST_OK || i_rsp_status == ST_EMPTY || i_rsp_status == ST_FULL)
        else $error("response status out of range");

    a_no_early_rsp: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response shown right after reset");

endmodule

bind fixed_block_pool_allocator fbpa_checker #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .OFFSET_BITS (OFFSET_BITS)
) u_fbpa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_offset (o_rsp.granted_offset),
    .i_rsp_status (o_rsp.status),
    .i_rsp_free   (o_rsp.free_blocks)
);

/* tb/fbpa_pool_checker.sv */
`timescale 1ns / 1ps

module fbpa_pool_checker
    import fbpa_pkg::*;
#(
    parameter int MAX_BLOCKS  = 256,
    parameter int OFFSET_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BB_W-1:0]      i_cfg_data,
    fbpa_req_if                  i_req,
    fbpa_rsp_if                  i_rsp,
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [OFFSET_BITS-1:0] granted;
        t_status                status;
        logic [FREE_W-1:0]      free;
    } pool_reply_t;

    logic [OFFSET_BITS-1:0] free_offsets [MAX_BLOCKS];
    int unsigned            free_depth;
    logic [BB_W-1:0]        blk_size;
    logic [PB_W-1:0]        blk_count;
    pool_reply_t            replies_due [$];
    int                     fail_total = 0;

    function automatic void refill_pool();
        int unsigned n;
        n = (blk_count > MAX_BLOCKS) ? MAX_BLOCKS : blk_count;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            free_offsets[i] = (i < n) ? OFFSET_BITS'(longint'(i) * longint'(blk_size)) : '0;
        end
        free_depth = n;
    endfunction

    function automatic pool_reply_t step_pool(input t_kind kind,
                                              input logic [OFFSET_BITS-1:0] offset);
        pool_reply_t r;
        r.granted = '0;
        r.status  = ST_OK;
        if (kind == KIND_ALLOC) begin
            if (free_depth == 0) begin
                r.status = ST_EMPTY;
            end else begin
                free_depth--;
                r.granted = free_offsets[free_depth];
            end
        end else if (free_depth >= MAX_BLOCKS) begin
            r.status = ST_FULL;
        end else begin
            free_offsets[free_depth] = offset;
            free_depth++;
        end
        r.free = FREE_W'(free_depth);
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        if (fail_total < 100) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        pool_reply_t want;
        if (!i_rst_n) begin
            blk_size  = BLOCK_BYTES_RST;
            blk_count = POOL_BLOCKS_RST;
            refill_pool();
            replies_due.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BLOCK_BYTES) begin
                    blk_size = i_cfg_data;
                    refill_pool();
                end else if (i_cfg_idx == CFG_POOL_BLOCKS) begin
                    blk_count = PB_W'(i_cfg_data);
                    refill_pool();
                end
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (replies_due.size() == 0) begin
                    flag_mismatch($sformatf("reply with offset %h while no request is open",
                                            i_rsp.granted_offset));
                end else begin
                    want = replies_due.pop_front();
                    if (i_rsp.granted_offset !== want.granted) begin
                        flag_mismatch($sformatf("granted_offset %h, predicted %h",
                                                i_rsp.granted_offset, want.granted));
                    end
                    if (i_rsp.status !== want.status) begin
                        flag_mismatch($sformatf("status %0d, predicted %0d",
                                                i_rsp.status, want.status));
                    end
                    if (i_rsp.free_blocks !== want.free) begin
                        flag_mismatch($sformatf("free_blocks %0d, predicted %0d",
                                                i_rsp.free_blocks, want.free));
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                replies_due.push_back(step_pool(i_req.kind, i_req.block_offset));
            end
        end
        o_pending    = replies_due.size();
        o_fail_count = fail_total;
    end

endmodule

/* tb/tb_fixed_block_pool_allocator.sv */
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator;
    import fbpa_pkg::*;

    localparam int MAX_BLOCKS  = 256;
    localparam int OFFSET_BITS = 24;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS  = 1450;
    localparam int PHASES      = 12;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [BB_W-1:0]      cfg_data = '0;

    int          fail_count;
    int          pending_cnt;
    int unsigned cycle_cnt     = 0;
    int          hold_cycles   = 0;
    bit          sender_gaps   = 1'b0;
    bit          receiver_gaps = 1'b0;
    logic [BB_W-1:0] cur_bb    = BLOCK_BYTES_RST;
    int          alloc_pct     = 50;

    fbpa_req_if #(.OFFSET_BITS(OFFSET_BITS)) req_ch ();
    fbpa_rsp_if #(.OFFSET_BITS(OFFSET_BITS)) rsp_ch ();

    fixed_block_pool_allocator #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .OFFSET_BITS(OFFSET_BITS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_req     (req_ch),
        .o_rsp     (rsp_ch)
    );

    fbpa_pool_checker #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .OFFSET_BITS(OFFSET_BITS)
    ) pool_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending_cnt)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("tb_fixed_block_pool_allocator: FAIL");
            $finish;
        end
    end

    initial begin
        int stall_left;
        stall_left = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                rsp_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 14);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_req(input t_kind kind, input logic [OFFSET_BITS-1:0] offset);
        if (sender_gaps && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= kind;
        req_ch.block_offset <= offset;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BB_W-1:0] value);
        req_ch.valid <= 1'b0;
        while (pending_cnt != 0) @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_BLOCK_BYTES) begin
            cur_bb = value;
        end
    endtask

    function automatic logic [OFFSET_BITS-1:0] pick_offset();
        if ($urandom_range(0, 9) < 7) begin
            return OFFSET_BITS'(longint'($urandom_range(0, MAX_BLOCKS - 1)) * longint'(cur_bb));
        end
        return OFFSET_BITS'($urandom);
    endfunction

    initial begin
        logic [BB_W-1:0] bb;
        logic [BB_W-1:0] pb;
        bit last_part;
        req_ch.valid        = 1'b0;
        req_ch.kind         = KIND_ALLOC;
        req_ch.block_offset = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_req(KIND_RELEASE, 24'hFFFFFF);
        send_req(KIND_ALLOC, '0);
        send_req(KIND_RELEASE, 24'hFFFFFF);
        send_req(KIND_ALLOC, 24'hFFFFFF);
        send_req(KIND_RELEASE, 24'h555555);
        send_req(KIND_RELEASE, 24'hAAAAAA);
        send_req(KIND_ALLOC, '0);
        send_req(KIND_ALLOC, '0);

        write_reg(CFG_BLOCK_BYTES, 16'hFFFF);
        write_reg(CFG_POOL_BLOCKS, 16'd2);
        send_req(KIND_ALLOC, '0);
        send_req(KIND_ALLOC, '0);
        send_req(KIND_ALLOC, '0);
        send_req(KIND_RELEASE, '0);
        send_req(KIND_ALLOC, '0);

        write_reg(CFG_BLOCK_BYTES, 16'd0);
        write_reg(CFG_POOL_BLOCKS, 16'd3);
        send_req(KIND_ALLOC, '0);
        send_req(KIND_ALLOC, '0);

        write_reg(CFG_POOL_BLOCKS, 16'd0);
        send_req(KIND_ALLOC, '0);
        send_req(KIND_RELEASE, 24'h123456);
        send_req(KIND_ALLOC, '0);

        write_reg(CFG_POOL_BLOCKS, 16'hFFFF);
        write_reg(CFG_BLOCK_BYTES, 16'hFFFF);
        send_req(KIND_ALLOC, '0);
        send_req(KIND_RELEASE, 24'hFF00FF);
        send_req(KIND_RELEASE, 24'h00FF00);

        write_reg(CFG_BLOCK_BYTES, 16'd1);
        write_reg(CFG_POOL_BLOCKS, 16'd1);
        send_req(KIND_ALLOC, '0);
        send_req(KIND_ALLOC, '0);

        for (int p = 0; p < PHASES; p++) begin
            last_part = (p >= PHASES - 2);
            case ($urandom_range(0, 4))
                0:       bb = 16'd0;
                1:       bb = 16'd1;
                2:       bb = 16'hFFFF;
                default: bb = 16'($urandom);
            endcase
            case ($urandom_range(0, 6))
                0:       pb = 16'd0;
                1:       pb = 16'($urandom_range(1, 8));
                2:       pb = 16'd256;
                3:       pb = 16'($urandom_range(257, 65535));
                default: pb = 16'($urandom_range(1, 256));
            endcase
            if (p == 0) begin
                bb = 16'hFFFF;
                pb = 16'd256;
            end else if (p == 1) begin
                bb = 16'd1;
                pb = 16'd1;
            end
            write_reg(CFG_BLOCK_BYTES, bb);
            write_reg(CFG_POOL_BLOCKS, pb);
            case ($urandom_range(0, 2))
                0:       alloc_pct = 25;
                1:       alloc_pct = 50;
                default: alloc_pct = 75;
            endcase
            sender_gaps   = !last_part && ($urandom_range(0, 3) != 0);
            receiver_gaps = !last_part && ($urandom_range(0, 3) != 0);
            if (p == 2) begin
                sender_gaps = 1'b0;
                hold_cycles = 400;
            end
            repeat (RAND_ITEMS / PHASES) begin
                if ($urandom_range(0, 99) < alloc_pct) begin
                    send_req(KIND_ALLOC, OFFSET_BITS'($urandom));
                end else begin
                    send_req(KIND_RELEASE, pick_offset());
                end
            end
        end

        req_ch.valid <= 1'b0;
        while (pending_cnt != 0) @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_fixed_block_pool_allocator: PASS");
        end else begin
            $display("tb_fixed_block_pool_allocator: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/fbpa_pkg.sv
rtl/fbpa_req_if.sv
rtl/fbpa_rsp_if.sv
rtl/fbpa_stack_mem.sv
rtl/fixed_block_pool_allocator.sv
rtl/fbpa_checker.sv
tb/fbpa_pool_checker.sv
tb/tb_fixed_block_pool_allocator.sv
